// ===== rtl/affine_matrix_builder_defines.svh =====
// Assertion macros for the affine matrix builder.
// Used by the top level; no other dependencies.
`ifndef AFFINE_MATRIX_BUILDER_DEFINES_SVH
`define AFFINE_MATRIX_BUILDER_DEFINES_SVH
`ifndef ASSERT_OFF
`define AMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AMB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AMB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/amb_pkg.sv =====
// Types, constants and fixed-point helpers of the affine matrix builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package amb_pkg;
    localparam int ATAN_N = 24;
    localparam int CW = 32;
    localparam int ZW = 33;
    localparam logic signed [CW-1:0] CORDIC_START = 32'sd652032874;
    localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } t_out_item;

    typedef struct packed {
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] c;
    } t_trig;

    typedef logic [8:0][31:0] t_rot;

    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        case (idx)
            5'd0:    f_atan = 32'h20000000;
            5'd1:    f_atan = 32'h12E4051E;
            5'd2:    f_atan = 32'h09FB385B;
            5'd3:    f_atan = 32'h051111D4;
            5'd4:    f_atan = 32'h028B0D43;
            5'd5:    f_atan = 32'h0145D7E1;
            5'd6:    f_atan = 32'h00A2F61E;
            5'd7:    f_atan = 32'h00517C55;
            5'd8:    f_atan = 32'h0028BE53;
            5'd9:    f_atan = 32'h00145F2F;
            5'd10:   f_atan = 32'h000A2F98;
            5'd11:   f_atan = 32'h000517CC;
            5'd12:   f_atan = 32'h00028BE6;
            5'd13:   f_atan = 32'h000145F3;
            5'd14:   f_atan = 32'h0000A2FA;
            5'd15:   f_atan = 32'h0000517D;
            5'd16:   f_atan = 32'h000028BE;
            5'd17:   f_atan = 32'h0000145F;
            5'd18:   f_atan = 32'h00000A30;
            5'd19:   f_atan = 32'h00000518;
            5'd20:   f_atan = 32'h0000028C;
            5'd21:   f_atan = 32'h00000146;
            5'd22:   f_atan = 32'h000000A3;
            5'd23:   f_atan = 32'h00000051;
            default: f_atan = 32'h0;
        endcase
    endfunction

    // Q2.30 product, rounded half up
    function automatic logic signed [31:0] f_mul30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + HALF_Q30;
        f_mul30 = p[61:30];
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [33:0] v);
        if (v > ONE_Q30) begin
            f_clamp = ONE_Q30[31:0];
        end else if (v < -ONE_Q30) begin
            f_clamp = 32'(-ONE_Q30);
        end else begin
            f_clamp = v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/amb_cordic.sv =====
// Pipelined rotation-mode CORDIC, one stage per iteration, sine and cosine in Q2.30.
// Depends on amb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amb_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [15:0]   i_angle,
    output logic               o_valid,
    output amb_pkg::t_trig     o_trig
);
    import amb_pkg::*;

    localparam int NS = (STEPS < ATAN_N) ? STEPS : ATAN_N;

    logic                 r_v    [0:NS];
    logic                 r_flip [0:NS];
    logic signed [CW-1:0] r_x    [0:NS];
    logic signed [CW-1:0] r_y    [0:NS];
    logic signed [ZW-1:0] r_z    [0:NS];
    logic                 r_ov;
    t_trig                r_trig;
    logic                 n_flip;
    logic [15:0]          n_ang;

    // fold the half turn around 180 degrees
    always_comb begin
        n_flip = 1'(((i_angle + 16'h4000) >> 15));
        n_ang  = n_flip ? (i_angle ^ 16'h8000) : i_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flip[0] <= n_flip;
        r_x[0]    <= CORDIC_START;
        r_y[0]    <= '0;
        r_z[0]    <= ZW'(signed'({n_ang, 16'h0}));
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic signed [ZW-1:0] n_at;
        assign n_at = signed'(ZW'(f_atan(5'(i))));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_flip[i+1] <= r_flip[i];
            if (!r_z[i][ZW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - n_at;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + n_at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_trig.s <= r_flip[NS] ? -r_y[NS] : r_y[NS];
        r_trig.c <= r_flip[NS] ? -r_x[NS] : r_x[NS];
    end

    assign o_valid = r_ov;
    assign o_trig  = r_trig;
endmodule
`default_nettype wire

// ===== rtl/amb_rot.sv =====
// Rotation matrix Rx*Ry*Rz from sines and cosines, three product/sum stages.
// Depends on amb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amb_rot (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire amb_pkg::t_trig    i_trx,
    input  wire amb_pkg::t_trig    i_try,
    input  wire amb_pkg::t_trig    i_trz,
    input  wire amb_pkg::t_in_item i_item,
    output logic                   o_valid,
    output amb_pkg::t_rot          o_rot,
    output amb_pkg::t_in_item      o_item
);
    import amb_pkg::*;

    logic r_v1, r_v2, r_v3;
    t_in_item r_it1, r_it2, r_it3;
    logic signed [31:0] r_sxsy, r_cxsy, r_cycz, r_cysz, r_sxcy, r_cxcy;
    logic signed [31:0] r_cxsz, r_cxcz, r_sxsz, r_sxcz, r_sy1, r_sz1, r_cz1;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic signed [31:0] r2_cycz, r2_cysz, r2_sxcy, r2_cxcy, r2_cxsz, r2_cxcz;
    logic signed [31:0] r2_sxsz, r2_sxcz, r2_sy;
    t_rot r_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it1  <= i_item;
        r_sxsy <= f_mul30(i_trx.s, i_try.s);
        r_cxsy <= f_mul30(i_trx.c, i_try.s);
        r_cycz <= f_mul30(i_try.c, i_trz.c);
        r_cysz <= f_mul30(i_try.c, i_trz.s);
        r_sxcy <= f_mul30(i_trx.s, i_try.c);
        r_cxcy <= f_mul30(i_trx.c, i_try.c);
        r_cxsz <= f_mul30(i_trx.c, i_trz.s);
        r_cxcz <= f_mul30(i_trx.c, i_trz.c);
        r_sxsz <= f_mul30(i_trx.s, i_trz.s);
        r_sxcz <= f_mul30(i_trx.s, i_trz.c);
        r_sy1  <= i_try.s;
        r_sz1  <= i_trz.s;
        r_cz1  <= i_trz.c;

        r_it2   <= r_it1;
        r_a     <= f_mul30(r_sxsy, r_cz1);
        r_b     <= f_mul30(r_sxsy, r_sz1);
        r_c     <= f_mul30(r_cxsy, r_cz1);
        r_d     <= f_mul30(r_cxsy, r_sz1);
        r2_cycz <= r_cycz;
        r2_cysz <= r_cysz;
        r2_sxcy <= r_sxcy;
        r2_cxcy <= r_cxcy;
        r2_cxsz <= r_cxsz;
        r2_cxcz <= r_cxcz;
        r2_sxsz <= r_sxsz;
        r2_sxcz <= r_sxcz;
        r2_sy   <= r_sy1;

        r_it3    <= r_it2;
        r_rot[0] <= f_clamp(34'(r2_cycz));
        r_rot[1] <= f_clamp(34'(r2_cysz));
        r_rot[2] <= f_clamp(-34'(r2_sy));
        r_rot[3] <= f_clamp(34'(r_a) - 34'(r2_cxsz));
        r_rot[4] <= f_clamp(34'(r_b) + 34'(r2_cxcz));
        r_rot[5] <= f_clamp(34'(r2_sxcy));
        r_rot[6] <= f_clamp(34'(r_c) + 34'(r2_sxsz));
        r_rot[7] <= f_clamp(34'(r_d) - 34'(r2_sxcz));
        r_rot[8] <= f_clamp(34'(r2_cxcy));
    end

    assign o_valid = r_v3;
    assign o_rot   = r_rot;
    assign o_item  = r_it3;
endmodule
`default_nettype wire

// ===== rtl/amb_row_out.sv =====
// Row sequencer: scales one rotation row per cycle and emits four rows per item.
// Depends on amb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amb_row_out (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire amb_pkg::t_rot     i_rot,
    input  wire amb_pkg::t_in_item i_item,
    output logic                   o_valid,
    output amb_pkg::t_out_item     o_result
);
    import amb_pkg::*;

    logic               r_act;
    logic [1:0]         r_row;
    t_rot               r_rot;
    t_in_item           r_item;
    logic               r_pv;
    logic [1:0]         r_prow;
    logic signed [63:0] r_p [3];
    logic               r_ov;
    t_out_item          r_out;
    logic signed [31:0] n_sc;
    logic signed [63:0] n_p [3];
    logic signed [63:0] n_rd [3];

    always_comb begin
        case (r_row)
            2'd0:    n_sc = r_item.scale_x;
            2'd1:    n_sc = r_item.scale_y;
            default: n_sc = r_item.scale_z;
        endcase
        for (int j = 0; j < 3; j++) begin
            case (r_row)
                2'd0:    n_p[j] = n_sc * $signed(r_rot[j]);
                2'd1:    n_p[j] = n_sc * $signed(r_rot[3 + j]);
                2'd2:    n_p[j] = n_sc * $signed(r_rot[6 + j]);
                default: n_p[j] = '0;
            endcase
            n_rd[j] = r_p[j] + HALF_Q30;
        end
        if (r_row == ROW_LAST) begin
            n_p[0] = 64'(r_item.move_x);
            n_p[1] = 64'(r_item.move_y);
            n_p[2] = 64'(r_item.move_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_row <= '0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_pv <= r_act;
            r_ov <= r_pv;
            if (i_valid) begin
                r_act <= 1'b1;
                r_row <= '0;
            end else if (r_act) begin
                r_row <= r_row + 2'd1;
                if (r_row == ROW_LAST) begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rot  <= i_rot;
            r_item <= i_item;
        end
        r_prow <= r_row;
        for (int j = 0; j < 3; j++) begin
            r_p[j] <= n_p[j];
        end
        r_out.row_index <= r_prow;
        r_out.last_row  <= (r_prow == ROW_LAST);
        if (r_prow == ROW_LAST) begin
            r_out.col0 <= r_p[0][31:0];
            r_out.col1 <= r_p[1][31:0];
            r_out.col2 <= r_p[2][31:0];
            r_out.col3 <= ONE_Q16;
        end else begin
            r_out.col0 <= n_rd[0][61:30];
            r_out.col1 <= n_rd[1][61:30];
            r_out.col2 <= n_rd[2][61:30];
            r_out.col3 <= '0;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;
endmodule
`default_nettype wire

// ===== rtl/affine_matrix_builder.sv =====
// Top level: builds the 4x4 affine matrix S*R*T and emits it row by row.
// Depends on amb_pkg, amb_cordic, amb_rot, amb_row_out and the defines header.
//
//  port       dir  meaning
//  i_start    in   offer an item (taken when o_busy is low)
//  i_item     in   scale, angles, translation
//  o_busy     out  item refused this cycle
//  o_valid    out  result strobe, one cycle per row
//  o_result   out  row index, four columns, last-row flag
//
// Items overlap in the pipeline: a new item is taken before earlier ones are done; four rows
// leave on one result port, one row a cycle. From accept to row 0 an item passes one pipeline
// stage per CORDIC iteration (CORDIC_STEPS, capped at 24), then product, sum and scaling stages.
// o_busy is high after each accept until r_hold counts down to zero. Synchronous reset clears
// valid bits and counters only. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "affine_matrix_builder_defines.svh"
module affine_matrix_builder #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire amb_pkg::t_in_item  i_item,
    output logic                    o_busy,
    output logic                    o_valid,
    output amb_pkg::t_out_item      o_result
);
    import amb_pkg::*;

    localparam int NS  = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam int LAT = NS + 2;

    logic [1:0] r_hold;
    logic       n_take;
    t_in_item   r_dly [0:LAT-1];
    logic       n_vx, n_vy, n_vz, n_rv;
    t_trig      n_tx, n_ty, n_tz;
    t_rot       n_rot;
    t_in_item   n_ritem;

    assign n_take = i_start && (r_hold == 2'd0);
    assign o_busy = (r_hold != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (n_take) begin
            r_hold <= 2'd3;
        end else if (r_hold != 2'd0) begin
            r_hold <= r_hold - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly[0] <= i_item;
        for (int k = 1; k < LAT; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    amb_cordic #(.STEPS(CORDIC_STEPS)) u_cx (
        .i_clk, .i_rst_n, .i_valid(n_take), .i_angle(i_item.angle_x),
        .o_valid(n_vx), .o_trig(n_tx)
    );
    amb_cordic #(.STEPS(CORDIC_STEPS)) u_cy (
        .i_clk, .i_rst_n, .i_valid(n_take), .i_angle(i_item.angle_y),
        .o_valid(n_vy), .o_trig(n_ty)
    );
    amb_cordic #(.STEPS(CORDIC_STEPS)) u_cz (
        .i_clk, .i_rst_n, .i_valid(n_take), .i_angle(i_item.angle_z),
        .o_valid(n_vz), .o_trig(n_tz)
    );

    amb_rot u_rot (
        .i_clk, .i_rst_n, .i_valid(n_vx && n_vy && n_vz),
        .i_trx(n_tx), .i_try(n_ty), .i_trz(n_tz), .i_item(r_dly[LAT-1]),
        .o_valid(n_rv), .o_rot(n_rot), .o_item(n_ritem)
    );

    amb_row_out u_out (
        .i_clk, .i_rst_n, .i_valid(n_rv), .i_rot(n_rot), .i_item(n_ritem),
        .o_valid, .o_result
    );

    `AMB_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, n_take, o_busy)
    `AMB_ASSERT_IMP(a_last_on_row3, i_clk, i_rst_n, o_valid, o_result.last_row == (o_result.row_index == ROW_LAST))
    `AMB_ASSERT_NEXT(a_rows_in_run, i_clk, i_rst_n, o_valid && !o_result.last_row, o_valid && (o_result.row_index == $past(o_result.row_index) + 2'd1))
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for affine_matrix_builder: directed items, then random items.
// Predicts the four matrix rows of every accepted item with its own CORDIC and products.
// Depends on amb_pkg and the affine_matrix_builder RTL.
`timescale 1ns / 1ps
module tb_top;
    import amb_pkg::*;

    localparam int STEPS = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_ITEMS = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam longint ANGLE_STEP[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam longint ROUND_Q30 = 64'sd536870912;

    typedef struct {
        t_in_item  item;
        bit        row3_typed;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    t_in_item   i_item;
    logic       o_busy;
    logic       o_valid;
    t_out_item  o_result;

    t_out_item  pending_rows[$];
    bit         failed;
    t_stim_row  stim_table[$];

    affine_matrix_builder #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic void cordic_sin_cos(input logic [15:0] ang, output longint s,
                                           output longint c);
        logic [16:0] shifted;
        logic [15:0] a;
        bit          flip;
        longint      x, y, z, xs, ys;
        shifted = {1'b0, ang} + 17'h04000;
        flip = shifted[15];
        a = flip ? (ang ^ 16'h8000) : ang;
        z = longint'($signed(a)) * 65536;
        x = 64'sd652032874;
        y = 0;
        for (int k = 0; k < STEPS && k < 24; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ANGLE_STEP[k];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ANGLE_STEP[k];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + ROUND_Q30) >>> 30;
    endfunction

    function automatic logic [31:0] scaled_entry(input logic signed [31:0] sc, input longint r);
        longint p;
        if (r > UNIT_Q30) r = UNIT_Q30;
        if (r < -UNIT_Q30) r = -UNIT_Q30;
        p = (longint'(sc) * r + ROUND_Q30) >>> 30;
        return p[31:0];
    endfunction

    task automatic queue_matrix_rows(input t_in_item it);
        longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        longint rot[3][3];
        logic signed [31:0] sc[3];
        t_out_item row;
        cordic_sin_cos(it.angle_x, sx, cx);
        cordic_sin_cos(it.angle_y, sy, cy);
        cordic_sin_cos(it.angle_z, sz, cz);
        sxsy = q30_product(sx, sy);
        cxsy = q30_product(cx, sy);
        rot[0][0] = q30_product(cy, cz);
        rot[0][1] = q30_product(cy, sz);
        rot[0][2] = -sy;
        rot[1][0] = q30_product(sxsy, cz) - q30_product(cx, sz);
        rot[1][1] = q30_product(sxsy, sz) + q30_product(cx, cz);
        rot[1][2] = q30_product(sx, cy);
        rot[2][0] = q30_product(cxsy, cz) + q30_product(sx, sz);
        rot[2][1] = q30_product(cxsy, sz) - q30_product(sx, cz);
        rot[2][2] = q30_product(cx, cy);
        sc[0] = it.scale_x;
        sc[1] = it.scale_y;
        sc[2] = it.scale_z;
        for (int r = 0; r < 3; r++) begin
            row.row_index = 2'(r);
            row.col0 = scaled_entry(sc[r], rot[r][0]);
            row.col1 = scaled_entry(sc[r], rot[r][1]);
            row.col2 = scaled_entry(sc[r], rot[r][2]);
            row.col3 = '0;
            row.last_row = 1'b0;
            pending_rows.push_back(row);
        end
        row.row_index = ROW_LAST;
        row.col0 = it.move_x;
        row.col1 = it.move_y;
        row.col2 = it.move_z;
        row.col3 = ONE_Q16;
        row.last_row = 1'b1;
        pending_rows.push_back(row);
    endtask

    task automatic send_item(input t_in_item it, input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_busy);
        queue_matrix_rows(it);
    endtask

    // translation row is a straight copy of the move fields, typed in here
    task automatic send_typed(input t_in_item it);
        t_out_item row3;
        send_item(it, 1'b1);
        row3 = pending_rows.pop_back();
        row3.row_index = 2'd3;
        row3.col0 = it.move_x;
        row3.col1 = it.move_y;
        row3.col2 = it.move_z;
        row3.col3 = 32'sd65536;
        row3.last_row = 1'b1;
        pending_rows.push_back(row3);
    endtask

    function automatic t_in_item make_item(input logic [31:0] sx, sy, sz,
                                           input logic [15:0] ax, ay, az,
                                           input logic [31:0] mx, my, mz);
        t_in_item it;
        it = '{sx, sy, sz, ax, ay, az, mx, my, mz};
        return it;
    endfunction

    function automatic logic [15:0] random_angle();
        logic [15:0] edges[8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                                  16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
        if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'($signed(17'($urandom)) );
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_rows.size() == 0) begin
                $display("%t unexpected row: got %p", $realtime, o_result);
                failed = 1'b1;
            end else begin
                want = pending_rows.pop_front();
                if (o_result.row_index !== want.row_index) begin
                    $display("%t row_index: expected %0d got %0d", $realtime,
                             want.row_index, o_result.row_index);
                    failed = 1'b1;
                end
                if (o_result.col0 !== want.col0) begin
                    $display("%t row %0d col0: expected %h got %h", $realtime,
                             want.row_index, want.col0, o_result.col0);
                    failed = 1'b1;
                end
                if (o_result.col1 !== want.col1) begin
                    $display("%t row %0d col1: expected %h got %h", $realtime,
                             want.row_index, want.col1, o_result.col1);
                    failed = 1'b1;
                end
                if (o_result.col2 !== want.col2) begin
                    $display("%t row %0d col2: expected %h got %h", $realtime,
                             want.row_index, want.col2, o_result.col2);
                    failed = 1'b1;
                end
                if (o_result.col3 !== want.col3) begin
                    $display("%t row %0d col3: expected %h got %h", $realtime,
                             want.row_index, want.col3, o_result.col3);
                    failed = 1'b1;
                end
                if (o_result.last_row !== want.last_row) begin
                    $display("%t row %0d last_row: expected %0b got %0b", $realtime,
                             want.row_index, want.last_row, o_result.last_row);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int waited;
        failed = 1'b0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stim_table = '{
            '{make_item(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1},
            '{make_item(32'h10000, 32'h10000, 32'h10000, 16'h0, 16'h0, 16'h0,
                        32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF), 1},
            '{make_item(32'h80000000, 32'h80000000, 32'h80000000, 16'h4000, 16'h4000,
                        16'h4000, 32'h80000000, 32'h7FFFFFFF, 32'h0), 1},
            '{make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hC000, 16'hC000,
                        16'hC000, 32'h12345678, 32'h0, 32'h1), 1},
            '{make_item(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h0,
                        16'h8000, 32'h0, 32'h0, 32'h0), 0},
            '{make_item(32'h80000000, 32'h80000000, 32'h80000000, 16'hC000, 16'h8000,
                        16'h4000, 32'h0, 32'h0, 32'h0), 0},
            '{make_item(32'h10000, 32'h10000, 32'h10000, 16'h3FFF, 16'h3FFF,
                        16'h3FFF, 32'h0, 32'h0, 32'h0), 0},
            '{make_item(32'h10000, 32'h10000, 32'h10000, 16'h7FFF, 16'hBFFF,
                        16'hFFFF, 32'h0, 32'h0, 32'h0), 0},
            '{make_item(32'hFFFF0000, 32'h20000, 32'h8000, 16'h2000, 16'h6000,
                        16'hA000, 32'h10000, 32'h20000, 32'h30000), 0},
            '{make_item(32'hFFFFFFFF, 32'h1, 32'h55555555, 16'hE000, 16'h1555,
                        16'h8001, 32'hAAAAAAAA, 32'h55555555, 32'hFFFF0000), 0}
        };
        foreach (stim_table[k]) begin
            if (stim_table[k].row3_typed) send_typed(stim_table[k].item);
            else send_item(stim_table[k].item, 1'b1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                i_start <= 1'b0;
                while (pending_rows.size() != 0) @(posedge i_clk);
            end
            send_item(make_item(random_value(), random_value(), random_value(),
                                random_angle(), random_angle(), random_angle(),
                                random_value(), random_value(), random_value()),
                      n < RANDOM_ITEMS - CALM_ITEMS);
        end
        i_start <= 1'b0;

        waited = 0;
        while (pending_rows.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_rows.size() != 0) begin
            $display("%t %0d rows never arrived", $realtime, pending_rows.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
